@@ src/trcd_pkg.sv @@
// package for the tile run-length column decoder
// holds default sizes, action and byte codes, and the sequencer state type
// no dependencies
package trcd_pkg;

    localparam int TILE_COLUMNS_DEF = 64;
    localparam int TILE_HEIGHT_DEF  = 64;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    localparam logic [7:0] BYTE_COL_REPEAT = 8'h01;
    localparam logic [7:0] BYTE_DOUBLE_BIT = 8'h10;

    localparam int ACTION_W    = 2;
    localparam int BYTE_W      = 8;
    localparam int RD_ADDR_W   = 11;
    localparam int COL_POS_W   = 7;
    localparam int ROW_POS_W   = 5;
    localparam int RUN_W       = 7;
    localparam int WIDE_W      = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_COPY,
        ST_READ,
        ST_RESULT
    } trcd_state_t;

endpackage

@@ src/tile_rle_column_decoder_core.sv @@
// tile run-length column decoder: byte stream into a column-major tile store
// depends on trcd_pkg
// Takes one word at a time and answers each with one result word holding the
// position after the word and, for a read, the stored byte. A mode byte, a
// start or an idle action goes from acceptance straight to the result state;
// a read inside the store first passes the registered store read state; a
// byte that writes n store entries makes them one after another in the write
// state, then closes the run;
// a column copy count c streams each copied column's rows through the memory
// read and write ports one row per cycle, then drains the column's last write.
// Input is stalled while a word is in progress; the result sits in an output
// register so the next word can be taken while it waits. The store has no reset.
module tile_rle_column_decoder_core
    import trcd_pkg::*;
#(
    parameter int TILE_COLUMNS = TILE_COLUMNS_DEF,
    parameter int TILE_HEIGHT  = TILE_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ACTION_W-1:0]   action,
    input  logic [BYTE_W-1:0]     byte_value,
    input  logic [RD_ADDR_W-1:0]  read_address,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_W-1:0]     read_data,
    output logic [COL_POS_W-1:0]  column_position,
    output logic [ROW_POS_W-1:0]  row_position,
    output logic                  tile_full
);

    localparam int ColHeight = TILE_HEIGHT / 2;
    localparam int StoreSize = TILE_COLUMNS * ColHeight;
    localparam int AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;
    localparam int ColW      = $clog2(TILE_COLUMNS + 1);
    localparam int RowW      = (ColHeight > 1) ? $clog2(ColHeight) : 1;

    logic [BYTE_W-1:0] tile_mem [StoreSize];

    trcd_state_t        state_reg, state_next;
    logic [ColW-1:0]    col_reg, col_next;
    logic [RowW-1:0]    row_reg, row_next;
    logic [RUN_W-1:0]   pend_run_reg, pend_run_next;
    logic               pend_copy_reg, pend_copy_next;
    logic [RUN_W-1:0]   run_left_reg, run_left_next;
    logic [BYTE_W-1:0]  wr_val_reg, wr_val_next;
    logic [BYTE_W-1:0]  copy_left_reg, copy_left_next;
    logic [RowW-1:0]    cp_row_reg, cp_row_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [AddrW-1:0]   wr_addr_reg, wr_addr_next;
    logic [BYTE_W-1:0]  res_data_reg, res_data_next;
    logic [BYTE_W-1:0]  rd_data_reg;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  read_data_reg, read_data_next;
    logic [COL_POS_W-1:0] column_position_reg, column_position_next;
    logic [ROW_POS_W-1:0] row_position_reg, row_position_next;
    logic               tile_full_reg, tile_full_next;

    logic               mem_we;
    logic [AddrW-1:0]   mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [AddrW-1:0]   mem_raddr;

    logic [WIDE_W-1:0]  dst_wide;
    logic [WIDE_W-1:0]  src_wide;
    logic [WIDE_W-1:0]  rd_wide;
    logic [WIDE_W-1:0]  col_wide;
    logic [WIDE_W-1:0]  row_wide;
    logic               col_full;
    logic               row_last;
    logic               cp_row_last;
    logic               out_free;

    assign dst_wide    = WIDE_W'(col_reg) * WIDE_W'(ColHeight) + WIDE_W'(row_reg);
    assign src_wide    = WIDE_W'(col_reg) * WIDE_W'(ColHeight) + WIDE_W'(cp_row_reg)
                         - WIDE_W'(ColHeight);
    assign rd_wide     = WIDE_W'(read_address);
    assign col_wide    = WIDE_W'(col_reg);
    assign row_wide    = WIDE_W'(row_reg);
    assign col_full    = (col_reg >= ColW'(TILE_COLUMNS));
    assign row_last    = (row_reg == RowW'(ColHeight - 1));
    assign cp_row_last = (cp_row_reg == RowW'(ColHeight - 1));
    assign out_free    = !out_valid_reg || !out_stall;

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign read_data       = read_data_reg;
    assign column_position = column_position_reg;
    assign row_position    = row_position_reg;
    assign tile_full       = tile_full_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tile_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= tile_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            pend_run_reg  <= '0;
            pend_copy_reg <= 1'b0;
            run_left_reg  <= '0;
            copy_left_reg <= '0;
            cp_row_reg    <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pend_run_reg  <= pend_run_next;
            pend_copy_reg <= pend_copy_next;
            run_left_reg  <= run_left_next;
            copy_left_reg <= copy_left_next;
            cp_row_reg    <= cp_row_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_val_reg          <= wr_val_next;
        wr_addr_reg         <= wr_addr_next;
        res_data_reg        <= res_data_next;
        read_data_reg       <= read_data_next;
        column_position_reg <= column_position_next;
        row_position_reg    <= row_position_next;
        tile_full_reg       <= tile_full_next;
    end

    always_comb
    begin
        state_next           = state_reg;
        col_next             = col_reg;
        row_next             = row_reg;
        pend_run_next        = pend_run_reg;
        pend_copy_next       = pend_copy_reg;
        run_left_next        = run_left_reg;
        wr_val_next          = wr_val_reg;
        copy_left_next       = copy_left_reg;
        cp_row_next          = cp_row_reg;
        wr_pend_next         = 1'b0;
        wr_addr_next         = wr_addr_reg;
        res_data_next        = res_data_reg;
        out_valid_next       = out_valid_reg && out_stall;
        read_data_next       = read_data_reg;
        column_position_next = column_position_reg;
        row_position_next    = row_position_reg;
        tile_full_next       = tile_full_reg;
        mem_we               = 1'b0;
        mem_waddr            = dst_wide[AddrW-1:0];
        mem_wdata            = wr_val_reg;
        mem_re               = 1'b0;
        mem_raddr            = rd_wide[AddrW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                res_data_next = '0;
                if (in_valid)
                begin
                    state_next = ST_RESULT;
                    case (action)
                        ACT_BYTE:
                        begin
                            if (pend_copy_reg)
                            begin
                                pend_copy_next = 1'b0;
                                copy_left_next = byte_value;
                                cp_row_next    = '0;
                                state_next     = ST_COPY;
                            end
                            else if (pend_run_reg != '0)
                            begin
                                run_left_next = pend_run_reg;
                                wr_val_next   = byte_value;
                                pend_run_next = '0;
                                state_next    = ST_WRITE;
                            end
                            else if (byte_value == BYTE_COL_REPEAT)
                            begin
                                pend_copy_next = 1'b1;
                            end
                            else if (byte_value[0])
                            begin
                                pend_run_next = byte_value[BYTE_W-1:1];
                            end
                            else if ((byte_value & BYTE_DOUBLE_BIT) != '0)
                            begin
                                run_left_next = RUN_W'(2);
                                wr_val_next   = byte_value & ~BYTE_DOUBLE_BIT;
                                state_next    = ST_WRITE;
                            end
                            else
                            begin
                                run_left_next = RUN_W'(1);
                                wr_val_next   = byte_value;
                                state_next    = ST_WRITE;
                            end
                        end
                        ACT_READ:
                        begin
                            if (rd_wide < WIDE_W'(StoreSize))
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        ACT_START:
                        begin
                            col_next       = '0;
                            row_next       = '0;
                            pend_run_next  = '0;
                            pend_copy_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                if (run_left_reg == '0 || col_full)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    mem_we        = 1'b1;
                    run_left_next = run_left_reg - RUN_W'(1);
                    if (row_last)
                    begin
                        row_next = '0;
                        col_next = col_reg + ColW'(1);
                    end
                    else
                    begin
                        row_next = row_reg + RowW'(1);
                    end
                end
            end
            ST_COPY:
            begin
                mem_we    = wr_pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = rd_data_reg;
                mem_raddr = src_wide[AddrW-1:0];
                if (cp_row_reg == '0 && wr_pend_reg)
                begin
                    // drain the last row before reading the column just written
                end
                else if (cp_row_reg == '0 && (copy_left_reg == '0 || col_full))
                begin
                    state_next = ST_RESULT;
                end
                else if (cp_row_reg == '0 && col_reg == '0)
                begin
                    col_next       = ColW'(1);
                    copy_left_next = copy_left_reg - BYTE_W'(1);
                end
                else
                begin
                    mem_re       = 1'b1;
                    wr_pend_next = 1'b1;
                    wr_addr_next = AddrW'(WIDE_W'(col_reg) * WIDE_W'(ColHeight)
                                          + WIDE_W'(cp_row_reg));
                    if (cp_row_last)
                    begin
                        cp_row_next    = '0;
                        col_next       = col_reg + ColW'(1);
                        copy_left_next = copy_left_reg - BYTE_W'(1);
                    end
                    else
                    begin
                        cp_row_next = cp_row_reg + RowW'(1);
                    end
                end
            end
            ST_READ:
            begin
                res_data_next = rd_data_reg;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    read_data_next       = res_data_reg;
                    column_position_next = col_wide[COL_POS_W-1:0];
                    row_position_next    = row_wide[ROW_POS_W-1:0];
                    tile_full_next       = (col_reg == ColW'(TILE_COLUMNS));
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ test/tile_rle_column_decoder_core_tb.sv @@
`timescale 1ns / 100ps
// testbench for tile_rle_column_decoder_core: a directed table, then random byte streams
// results are checked against typed rows or an in-bench model of store and position
// depends on trcd_pkg and tile_rle_column_decoder_core
module tile_rle_column_decoder_core_tb;
    import trcd_pkg::*;

    localparam int COLS            = TILE_COLUMNS_DEF;
    localparam int COL_H           = TILE_HEIGHT_DEF / 2;
    localparam int STORE_LEN       = COLS * COL_H;
    localparam int RANDOM_WORDS    = 500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 64;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]    data;
        logic [COL_POS_W-1:0] col;
        logic [ROW_POS_W-1:0] row;
        logic                 full;
    } tile_word_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  act;
        logic [BYTE_W-1:0]    b;
        logic [RD_ADDR_W-1:0] a;
        bit                   typed;
        tile_word_t           w;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [ACTION_W-1:0]  action;
    logic [BYTE_W-1:0]    byte_value;
    logic [RD_ADDR_W-1:0] read_address;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_W-1:0]    read_data;
    logic [COL_POS_W-1:0] column_position;
    logic [ROW_POS_W-1:0] row_position;
    logic                 tile_full;

    logic [BYTE_W-1:0]    shadow_mem [STORE_LEN];
    bit                   shadow_known [STORE_LEN];
    logic [COL_POS_W-1:0] cur_col = '0;
    logic [ROW_POS_W-1:0] cur_row = '0;
    logic [RUN_W-1:0]     run_left = '0;
    bit                   copy_next = 1'b0;
    int                   last_written = -1;

    tile_word_t tile_words_due [$];
    stim_row_t  directed_rows [$];
    tile_word_t blank_word = '0;
    int         sent_count = 0;
    int         mismatch_count = 0;
    int         big_copies_left = 4;
    bit         in_quiet = 1'b0;
    bit         out_quiet = 1'b0;
    bit         stimulus_done = 1'b0;

    tile_rle_column_decoder_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .byte_value      (byte_value),
        .read_address    (read_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .column_position (column_position),
        .row_position    (row_position),
        .tile_full       (tile_full)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [RD_ADDR_W-1:0] rand_addr();
        return RD_ADDR_W'($urandom_range(0, 2047));
    endfunction

    function automatic void store_byte(input logic [BYTE_W-1:0] v);
        int addr;
        if (cur_col >= COLS)
            return;
        addr = int'(cur_col) * COL_H + int'(cur_row);
        shadow_mem[addr]   = v;
        shadow_known[addr] = 1'b1;
        last_written       = addr;
        if (int'(cur_row) == COL_H - 1)
        begin
            cur_row = '0;
            cur_col = cur_col + 1'b1;
        end
        else
            cur_row = cur_row + 1'b1;
    endfunction

    function automatic void copy_column();
        int dst;
        int r;
        if (cur_col >= COLS)
            return;
        if (cur_col != 0)
        begin
            dst = int'(cur_col) * COL_H;
            for (r = 0; r < COL_H; r++)
            begin
                shadow_mem[dst + r]   = shadow_mem[dst - COL_H + r];
                shadow_known[dst + r] = shadow_known[dst - COL_H + r];
            end
        end
        cur_col = cur_col + 1'b1;
    endfunction

    function automatic void feed_byte(input logic [BYTE_W-1:0] b);
        int k;
        if (copy_next)
        begin
            for (k = 0; k < int'(b); k++)
                copy_column();
            copy_next = 1'b0;
        end
        else if (run_left != 0)
        begin
            for (k = 0; k < int'(run_left); k++)
                store_byte(b);
            run_left = '0;
        end
        else if (b == BYTE_COL_REPEAT)
            copy_next = 1'b1;
        else if (b[0])
            run_left = b[7:1];
        else if ((b & BYTE_DOUBLE_BIT) != 0)
        begin
            store_byte(b & ~BYTE_DOUBLE_BIT);
            store_byte(b & ~BYTE_DOUBLE_BIT);
        end
        else
            store_byte(b);
    endfunction

    function automatic tile_word_t decode_word(input logic [ACTION_W-1:0] act,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [RD_ADDR_W-1:0] a);
        tile_word_t w;
        w.data = '0;
        case (act)
            ACT_BYTE:
                feed_byte(b);
            ACT_READ:
                if (int'(a) < STORE_LEN)
                    w.data = shadow_mem[a];
            ACT_START:
            begin
                cur_col   = '0;
                cur_row   = '0;
                run_left  = '0;
                copy_next = 1'b0;
            end
            default:
                ;
        endcase
        w.col  = cur_col;
        w.row  = cur_row;
        w.full = (cur_col >= COLS);
        return w;
    endfunction

    function automatic int pick_read_address();
        int a;
        int tries;
        for (tries = 0; tries < 8; tries++)
        begin
            a = $urandom_range(0, STORE_LEN - 1);
            if (shadow_known[a])
                return a;
        end
        if (last_written >= 0 && shadow_known[last_written])
            return last_written;
        return -1;
    endfunction

    function automatic logic [BYTE_W-1:0] copy_count();
        if (big_copies_left > 0 && $urandom_range(0, 49) == 0)
        begin
            big_copies_left--;
            return BYTE_W'($urandom_range(0, 255));
        end
        return BYTE_W'($urandom_range(0, 3));
    endfunction

    function automatic int idle_cycles(input bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic void add_row(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                                    input logic [RD_ADDR_W-1:0] a, input bit typed,
                                    input logic [BYTE_W-1:0] d, input logic [COL_POS_W-1:0] c,
                                    input logic [ROW_POS_W-1:0] r, input logic f);
        stim_row_t row;
        row.act   = act;
        row.b     = b;
        row.a     = a;
        row.typed = typed;
        row.w     = {d, c, r, f};
        directed_rows.push_back(row);
    endfunction

    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                             input logic [RD_ADDR_W-1:0] a, input bit typed,
                             input tile_word_t typed_word);
        int gap;
        tile_word_t w;
        if ($urandom_range(0, 39) == 0)
            in_quiet = ($urandom_range(0, 2) == 0);
        gap = idle_cycles(in_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        byte_value   <= b;
        read_address <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        w = decode_word(act, b, a);
        if (typed)
            tile_words_due.push_back(typed_word);
        else
            tile_words_due.push_back(w);
        if (act != ACT_NOP)
            sent_count++;
    endtask

    task automatic send_random_group();
        int pick;
        int ra;
        logic [BYTE_W-1:0] mode;
        pick = $urandom_range(0, 99);
        if (copy_next)
            send_word(ACT_BYTE, copy_count(), rand_addr(), 1'b0, blank_word);
        else if (cur_col >= COLS && pick < 60)
            send_word(ACT_START, rand_byte(), rand_addr(), 1'b0, blank_word);
        else if (pick < 30)
        begin
            mode    = rand_byte();
            mode[0] = 1'b0;
            send_word(ACT_BYTE, mode, rand_addr(), 1'b0, blank_word);
        end
        else if (pick < 48)
        begin
            mode    = rand_byte();
            mode[0] = 1'b1;
            if (mode == BYTE_COL_REPEAT)
                mode = 8'h03;
            send_word(ACT_BYTE, mode, rand_addr(), 1'b0, blank_word);
            send_word(ACT_BYTE, rand_byte(), rand_addr(), 1'b0, blank_word);
        end
        else if (pick < 58)
        begin
            send_word(ACT_BYTE, BYTE_COL_REPEAT, rand_addr(), 1'b0, blank_word);
            send_word(ACT_BYTE, copy_count(), rand_addr(), 1'b0, blank_word);
        end
        else if (pick < 73)
        begin
            ra = pick_read_address();
            if (ra >= 0)
                send_word(ACT_READ, rand_byte(), RD_ADDR_W'(ra), 1'b0, blank_word);
            else
                send_word(ACT_NOP, rand_byte(), rand_addr(), 1'b0, blank_word);
        end
        else if (pick < 79)
            send_word(ACT_START, rand_byte(), rand_addr(), 1'b0, blank_word);
        else if (pick < 83)
            send_word(ACT_NOP, rand_byte(), rand_addr(), 1'b0, blank_word);
        else if (pick < 92)
            send_word(ACT_BYTE, BYTE_W'($urandom_range(2, 255)), rand_addr(), 1'b0,
                      blank_word);
        else
        begin
            // mode byte followed by another action before its data byte
            mode    = rand_byte();
            mode[0] = 1'b1;
            if ($urandom_range(0, 1) == 0)
                mode = BYTE_COL_REPEAT;
            send_word(ACT_BYTE, mode, rand_addr(), 1'b0, blank_word);
            pick = $urandom_range(0, 2);
            ra   = pick_read_address();
            if (pick == 0)
                send_word(ACT_START, rand_byte(), rand_addr(), 1'b0, blank_word);
            else if (pick == 1 && ra >= 0)
                send_word(ACT_READ, rand_byte(), RD_ADDR_W'(ra), 1'b0, blank_word);
            else
                send_word(ACT_NOP, rand_byte(), rand_addr(), 1'b0, blank_word);
        end
    endtask

    initial
    begin : sender
        int i;
        in_valid     <= 1'b0;
        action       <= ACT_BYTE;
        byte_value   <= '0;
        read_address <= '0;
        while (rst_n !== 1'b1)
            @(posedge clk);

        add_row(ACT_START, 8'h00, 11'd0,    1'b1, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_NOP,   8'hFF, 11'h7FF,  1'b1, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h00, 11'd0,    1'b1, 8'h00, 7'd0,  5'd1, 1'b0);
        add_row(ACT_READ,  8'h00, 11'd0,    1'b1, 8'h00, 7'd0,  5'd1, 1'b0);
        add_row(ACT_BYTE,  8'hFE, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h10, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'hEE, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h03, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h01, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'hFF, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'hFF, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_READ,  8'h00, 11'd133,  1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h01, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h00, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h01, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h02, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_READ,  8'hFF, 11'd163,  1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h07, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_START, 8'h00, 11'd0,    1'b1, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h04, 11'd0,    1'b1, 8'h00, 7'd0,  5'd1, 1'b0);
        add_row(ACT_BYTE,  8'h01, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'hFF, 11'd0,    1'b1, 8'h00, 7'd64, 5'd1, 1'b1);
        add_row(ACT_BYTE,  8'h00, 11'd0,    1'b1, 8'h00, 7'd64, 5'd1, 1'b1);
        add_row(ACT_BYTE,  8'h01, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_BYTE,  8'h03, 11'd0,    1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_READ,  8'h00, 11'h7FF,  1'b0, 8'h00, 7'd0,  5'd0, 1'b0);
        add_row(ACT_START, 8'h00, 11'd0,    1'b1, 8'h00, 7'd0,  5'd0, 1'b0);

        for (i = 0; i < directed_rows.size(); i++)
            send_word(directed_rows[i].act, directed_rows[i].b, directed_rows[i].a,
                      directed_rows[i].typed, directed_rows[i].w);
        while (sent_count < directed_rows.size() + RANDOM_WORDS)
            send_random_group();
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin : receiver
        int hold;
        int seen;
        bit held_off;
        tile_word_t want;
        hold     = 0;
        seen     = 0;
        held_off = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                seen++;
                if (tile_words_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: data %0h col %0d row %0d full %0d",
                                 read_data, column_position, row_position, tile_full);
                end
                else
                begin
                    want = tile_words_due.pop_front();
                    if (read_data !== want.data || column_position !== want.col ||
                        row_position !== want.row || tile_full !== want.full)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("word %0d mismatch: expected data %0h col %0d row %0d",
                                     seen, want.data, want.col, want.row,
                                     " full %0d, got data %0h col %0d row %0d full %0d",
                                     want.full, read_data, column_position, row_position,
                                     tile_full);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    out_quiet = ($urandom_range(0, 2) == 0);
                hold = idle_cycles(out_quiet);
                if (!held_off && seen == 150)
                begin
                    hold     = HOLD_OFF_CYCLES;
                    held_off = 1'b1;
                end
            end
            else if (hold > 0)
                hold--;
            out_stall <= (hold > 0);
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : main_seq
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stimulus_done && tile_words_due.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && tile_words_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
